// ===== design/cpu_6502_subset_core_defines.svh =====
// Assertion macros used by the core's top-level RTL file.
`ifndef CPU_6502_SUBSET_CORE_DEFINES_SVH
`define CPU_6502_SUBSET_CORE_DEFINES_SVH

// Check that an implication holds at every clock edge outside reset.
`define CSC_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define CSC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== design/csc_pkg.sv =====
// Package: command codes, opcodes, addressing modes, instruction kinds, reset values, sizing constants and the decoder.
`timescale 1ns / 1ps
`default_nettype none
package csc_pkg;
    localparam int MEM_ADDR_BITS_DEF = 16;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_RESET = 2'd2,
        CMD_TICK  = 2'd3
    } t_cmd;

    localparam logic [7:0] OP_NOP = 8'hEA;
    localparam logic [7:0] OP_BNE = 8'hD0;
    localparam logic [7:0] OP_JMP = 8'h4C;
    localparam logic [7:0] OP_TAX = 8'hAA;
    localparam logic [7:0] OP_TAY = 8'hA8;
    localparam logic [7:0] OP_TXA = 8'h8A;
    localparam logic [7:0] OP_TYA = 8'h98;
    localparam logic [7:0] OP_INX = 8'hE8;
    localparam logic [7:0] OP_INY = 8'hC8;
    localparam logic [7:0] OP_DEX = 8'hCA;
    localparam logic [7:0] OP_DEY = 8'h88;

    localparam logic [15:0] RESET_VEC = 16'hFFFC;
    localparam logic [7:0]  SP_RESET  = 8'hFD;
    localparam logic [7:0]  P_RESET   = 8'h20;

    typedef enum logic [3:0] {
        M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABSX, M_ABSY, M_INDX, M_INDY
    } t_mode;

    typedef enum logic [2:0] {
        K_NONE, K_LDA, K_LDX, K_LDY, K_STA, K_IMPL, K_BNE, K_JMP
    } t_kind;

    typedef struct packed {
        t_kind kind;
        t_mode mode;
        logic  known;
    } t_dec;

    function automatic t_dec decode(input logic [7:0] op);
        t_dec d;
        d.kind  = K_NONE;
        d.mode  = M_IMM;
        d.known = 1'b1;
        unique case (op)
            8'hEA: d.kind = K_NONE;
            8'hA9: begin d.kind = K_LDA; d.mode = M_IMM;  end
            8'hA5: begin d.kind = K_LDA; d.mode = M_ZP;   end
            8'hB5: begin d.kind = K_LDA; d.mode = M_ZPX;  end
            8'hAD: begin d.kind = K_LDA; d.mode = M_ABS;  end
            8'hBD: begin d.kind = K_LDA; d.mode = M_ABSX; end
            8'hB9: begin d.kind = K_LDA; d.mode = M_ABSY; end
            8'hA1: begin d.kind = K_LDA; d.mode = M_INDX; end
            8'hB1: begin d.kind = K_LDA; d.mode = M_INDY; end
            8'hA2: begin d.kind = K_LDX; d.mode = M_IMM;  end
            8'hA6: begin d.kind = K_LDX; d.mode = M_ZP;   end
            8'hB6: begin d.kind = K_LDX; d.mode = M_ZPY;  end
            8'hAE: begin d.kind = K_LDX; d.mode = M_ABS;  end
            8'hBE: begin d.kind = K_LDX; d.mode = M_ABSY; end
            8'hA0: begin d.kind = K_LDY; d.mode = M_IMM;  end
            8'hA4: begin d.kind = K_LDY; d.mode = M_ZP;   end
            8'hB4: begin d.kind = K_LDY; d.mode = M_ZPX;  end
            8'hAC: begin d.kind = K_LDY; d.mode = M_ABS;  end
            8'hBC: begin d.kind = K_LDY; d.mode = M_ABSX; end
            8'h85: begin d.kind = K_STA; d.mode = M_ZP;   end
            8'h95: begin d.kind = K_STA; d.mode = M_ZPX;  end
            8'h8D: begin d.kind = K_STA; d.mode = M_ABS;  end
            8'h9D: begin d.kind = K_STA; d.mode = M_ABSX; end
            8'h99: begin d.kind = K_STA; d.mode = M_ABSY; end
            8'h81: begin d.kind = K_STA; d.mode = M_INDX; end
            8'h91: begin d.kind = K_STA; d.mode = M_INDY; end
            8'hAA, 8'hA8, 8'h8A, 8'h98, 8'hE8, 8'hC8, 8'hCA, 8'h88: d.kind = K_IMPL;
            8'hD0: d.kind = K_BNE;
            8'h4C: d.kind = K_JMP;
            default: d.known = 1'b0;
        endcase
        return d;
    endfunction
endpackage
`default_nettype wire

// ===== design/csc_if.sv =====
// Valid/ready channel interfaces for command items and result items.
`timescale 1ns / 1ps
`default_nettype none
interface csc_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  data;
    modport source (output valid, cmd, addr, data, input ready);
    modport sink (input valid, cmd, addr, data, output ready);
endinterface

interface csc_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  acc_value;
    logic [7:0]  index_x_value;
    logic [7:0]  index_y_value;
    logic [7:0]  stack_value;
    logic [7:0]  status_value;
    logic [15:0] counter_value;
    logic [7:0]  read_data;
    logic        busy_res;
    logic        executed;
    logic        unknown_opcode;
    modport source (output valid, acc_value, index_x_value, index_y_value, stack_value,
                    status_value, counter_value, read_data, busy_res, executed,
                    unknown_opcode, input ready);
    modport sink (input valid, acc_value, index_x_value, index_y_value, stack_value,
                  status_value, counter_value, read_data, busy_res, executed,
                  unknown_opcode, output ready);
endinterface
`default_nettype wire

// ===== design/cpu_6502_subset_core.sv =====
// Top level: 6502 subset core with an internal byte memory.
//
// Usage:
//   i_cmd (sink) carries one command item: cmd, addr, data. cmd selects load
//   memory byte, read memory byte, reset, or clock tick. o_res (source) returns
//   exactly one result item per command: A, X, Y, S, P, PC after the item, the
//   read byte, busy, executed and unknown-opcode flags.
//   Steps: load, read and a counting tick go straight from accept to the
//   result; reset reads the two vector bytes, then loads the vector into PC;
//   an executing tick makes one memory access per step (opcode, operands,
//   pointer bytes, data) before its result. All accesses go through the one
//   port of the main memory, which sets the rate: one item at a time, the
//   next item accepted once the result of the last one is registered.
//   The result sits in an output register; a new item is accepted while it
//   waits, and that item is worked on up to the point of delivering, where it
//   holds until the receiver takes the pending result.
//   Reset (i_rst_n low, synchronous) sets A, X, Y to 0, S to 0xFD, P to 0x20,
//   PC and the cycle counter to 0. Memory contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "cpu_6502_subset_core_defines.svh"
module cpu_6502_subset_core
    import csc_pkg::*;
#(
    parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    csc_cmd_if.sink   i_cmd,
    csc_res_if.source o_res
);
    localparam int DEPTH = 1 << MEM_ADDR_BITS;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_OP   = 7'b0000010,  // opcode read in flight
        S_B1   = 7'b0000100,  // first operand byte in flight
        S_B2   = 7'b0001000,  // second operand byte in flight
        S_P1   = 7'b0010000,  // pointer low byte in flight
        S_P2   = 7'b0100000,  // pointer high byte in flight
        S_DONE = 7'b1000000   // data or read in flight, or finish
    } t_state;

    t_state r_state, n_state;
    logic [7:0]  r_a, n_a, r_x, n_x, r_y, n_y, r_p, n_p;
    logic [15:0] r_pc, n_pc;
    logic [2:0]  r_cyc, n_cyc;
    logic [1:0]  r_cmd, n_cmd;
    logic [15:0] r_ea, n_ea;     // effective address / pointer
    logic [7:0]  r_lo, n_lo;
    t_dec        r_dec, n_dec;
    logic        r_cross, n_cross;
    logic        r_rd_pend, n_rd_pend;  // memory data due in S_DONE
    logic        r_exe, n_exe, r_unk, n_unk;
    logic        r_ov, n_ov;

    logic                     mem_we;
    logic [MEM_ADDR_BITS-1:0] mem_addr;
    logic [15:0]              mem_a16;
    logic [15:0]              r_ma;     // last address issued, held while stalled
    logic [7:0]               mem_wd, mem_rd;

    csc_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_addr (mem_addr),
        .i_wdata(mem_wd),
        .o_rdata(mem_rd)
    );

    assign mem_addr = mem_a16[MEM_ADDR_BITS-1:0];

    logic can_out;
    assign can_out = !r_ov || o_res.ready;
    assign i_cmd.ready = (r_state == S_IDLE);

    // Result register fields.
    logic [7:0] r_o_rd, n_o_rd;
    logic [15:0] idx_sum;
    logic [15:0] br_tgt;
    logic [7:0]  ld_val;

    always_comb begin
        n_state = r_state;
        n_a = r_a; n_x = r_x; n_y = r_y; n_p = r_p; n_pc = r_pc; n_cyc = r_cyc;
        n_cmd = r_cmd; n_ea = r_ea; n_lo = r_lo; n_dec = r_dec; n_cross = r_cross;
        n_rd_pend = r_rd_pend; n_exe = r_exe; n_unk = r_unk; n_o_rd = r_o_rd;
        n_ov = r_ov && !o_res.ready;
        mem_we = 1'b0; mem_a16 = r_pc; mem_wd = r_a;
        idx_sum = 16'd0; br_tgt = 16'd0; ld_val = mem_rd;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd = i_cmd.cmd; n_exe = 1'b0; n_unk = 1'b0;
                    n_rd_pend = 1'b0;
                    unique case (t_cmd'(i_cmd.cmd))
                        CMD_LOAD: begin
                            mem_we = 1'b1; mem_a16 = i_cmd.addr; mem_wd = i_cmd.data;
                            n_state = S_DONE;
                        end
                        CMD_READ: begin
                            mem_a16 = i_cmd.addr; n_rd_pend = 1'b1; n_state = S_DONE;
                        end
                        CMD_RESET: begin
                            mem_a16 = RESET_VEC; n_state = S_P1;
                        end
                        default: begin
                            if (r_cyc != 3'd0) begin
                                n_cyc = r_cyc - 3'd1; n_state = S_DONE;
                            end else begin
                                mem_a16 = r_pc; n_pc = r_pc + 16'd1;
                                n_exe = 1'b1; n_cross = 1'b0; n_state = S_OP;
                            end
                        end
                    endcase
                end
            end
            S_OP: begin
                n_dec = decode(mem_rd);
                n_unk = !n_dec.known;
                n_state = S_DONE;
                mem_a16 = r_pc;
                if (n_dec.kind == K_LDA || n_dec.kind == K_LDX || n_dec.kind == K_LDY ||
                    n_dec.kind == K_STA || n_dec.kind == K_BNE || n_dec.kind == K_JMP) begin
                    n_pc = r_pc + 16'd1;
                    n_ea = r_pc;
                    if (n_dec.kind == K_BNE || n_dec.kind == K_JMP ||
                        n_dec.mode != M_IMM) begin
                        n_state = S_B1;
                    end else begin
                        n_rd_pend = 1'b1;
                    end
                end else if (n_dec.kind == K_IMPL) begin
                    unique case (mem_rd)
                        OP_TAX: begin n_x = r_a; ld_val = r_a; end
                        OP_TAY: begin n_y = r_a; ld_val = r_a; end
                        OP_TXA: begin n_a = r_x; ld_val = r_x; end
                        OP_TYA: begin n_a = r_y; ld_val = r_y; end
                        OP_INX: begin n_x = r_x + 8'd1; ld_val = n_x; end
                        OP_INY: begin n_y = r_y + 8'd1; ld_val = n_y; end
                        OP_DEX: begin n_x = r_x - 8'd1; ld_val = n_x; end
                        default: begin n_y = r_y - 8'd1; ld_val = n_y; end
                    endcase
                    n_p = {ld_val[7], r_p[6:2], ld_val == 8'd0, r_p[0]};
                end
            end
            S_B1: begin
                mem_a16 = r_pc;
                if (r_dec.kind == K_BNE) begin
                    if (!r_p[1]) begin
                        br_tgt = r_pc + {{8{mem_rd[7]}}, mem_rd};
                        n_pc = br_tgt;
                        n_cross = 1'b1;  // taken
                        n_lo = {7'd0, br_tgt[15:8] != r_pc[15:8]};
                    end
                    n_state = S_DONE;
                end else begin
                    unique case (r_dec.mode)
                        M_ZP:  begin n_ea = {8'd0, mem_rd}; end
                        M_ZPX: begin n_ea = {8'd0, mem_rd + r_x}; end
                        M_ZPY: begin n_ea = {8'd0, mem_rd + r_y}; end
                        M_INDX: begin n_ea = {8'd0, mem_rd + r_x}; end
                        default: begin n_ea = {8'd0, mem_rd}; end
                    endcase
                    if (r_dec.mode == M_ABS || r_dec.mode == M_ABSX ||
                        r_dec.mode == M_ABSY || r_dec.kind == K_JMP) begin
                        n_lo = mem_rd; n_pc = r_pc + 16'd1; n_state = S_B2;
                    end else if (r_dec.mode == M_INDX || r_dec.mode == M_INDY) begin
                        mem_a16 = n_ea; n_state = S_P1;
                    end else begin
                        mem_a16 = n_ea; mem_we = (r_dec.kind == K_STA);
                        n_rd_pend = !mem_we; n_state = S_DONE;
                    end
                end
            end
            S_B2: begin
                if (r_dec.kind == K_JMP) begin
                    n_pc = {mem_rd, r_lo}; n_state = S_DONE;
                end else begin
                    idx_sum = {mem_rd, r_lo};
                    if (r_dec.mode == M_ABSX) idx_sum = {mem_rd, r_lo} + {8'd0, r_x};
                    if (r_dec.mode == M_ABSY) idx_sum = {mem_rd, r_lo} + {8'd0, r_y};
                    n_cross = idx_sum[15:8] != mem_rd;
                    n_ea = idx_sum; mem_a16 = idx_sum;
                    mem_we = (r_dec.kind == K_STA); n_rd_pend = !mem_we;
                    n_state = S_DONE;
                end
            end
            S_P1: begin
                // pointer low byte (or reset vector low byte) arriving
                n_lo = mem_rd;
                if (r_cmd == CMD_RESET) mem_a16 = RESET_VEC + 16'd1;
                else mem_a16 = {8'd0, r_ea[7:0] + 8'd1};
                n_state = S_P2;
            end
            S_P2: begin
                if (r_cmd == CMD_RESET) begin
                    n_pc = {mem_rd, r_lo}; n_state = S_DONE;
                end else begin
                    idx_sum = {mem_rd, r_lo};
                    if (r_dec.mode == M_INDY) idx_sum = {mem_rd, r_lo} + {8'd0, r_y};
                    n_cross = (r_dec.mode == M_INDY) && (idx_sum[15:8] != mem_rd);
                    mem_a16 = idx_sum;
                    mem_we = (r_dec.kind == K_STA); n_rd_pend = !mem_we;
                    n_state = S_DONE;
                end
            end
            default: begin  // S_DONE
                // Re-read the last address so the data holds while the output stalls.
                mem_a16 = r_ma;
                if (can_out) begin
                    n_ov = 1'b1;
                    n_state = S_IDLE;
                    n_o_rd = (r_cmd == CMD_READ) ? mem_rd : 8'd0;
                    if (r_cmd == CMD_RESET) begin
                        n_a = 8'd0; n_x = 8'd0; n_y = 8'd0; n_p = P_RESET; n_cyc = 3'd0;
                    end
                    if (r_cmd == CMD_TICK && r_exe) begin
                        if (r_rd_pend) begin
                            unique case (r_dec.kind)
                                K_LDA: n_a = mem_rd;
                                K_LDX: n_x = mem_rd;
                                default: n_y = mem_rd;
                            endcase
                            n_p = {mem_rd[7], r_p[6:2], mem_rd == 8'd0, r_p[0]};
                        end
                        if (r_dec.kind == K_BNE)
                            n_cyc = 3'd1 + {2'd0, r_cross} + {2'd0, r_cross & r_lo[0]};
                        else
                            n_cyc = 3'd1 + {2'd0, r_cross};
                    end
                end
            end
        endcase
    end

    logic [7:0] r_sp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_a <= 8'd0; r_x <= 8'd0; r_y <= 8'd0; r_p <= P_RESET; r_sp <= SP_RESET;
            r_pc <= 16'd0; r_cyc <= 3'd0; r_ov <= 1'b0;
            r_exe <= 1'b0; r_unk <= 1'b0; r_rd_pend <= 1'b0; r_cmd <= CMD_LOAD;
        end else begin
            r_state <= n_state;
            r_a <= n_a; r_x <= n_x; r_y <= n_y; r_p <= n_p; r_sp <= SP_RESET;
            r_pc <= n_pc; r_cyc <= n_cyc; r_ov <= n_ov;
            r_exe <= n_exe; r_unk <= n_unk; r_rd_pend <= n_rd_pend; r_cmd <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ea <= n_ea; r_lo <= n_lo; r_dec <= n_dec; r_cross <= n_cross;
        r_o_rd <= n_o_rd; r_ma <= mem_a16;
    end

    // Output register: fields captured when a result is launched.
    logic [7:0]  r_oa, r_ox, r_oy, r_op;
    logic [15:0] r_opc;
    logic        r_obusy, r_oexe, r_ounk;
    logic        launch;
    assign launch = (r_state == S_DONE) && can_out;

    always_ff @(posedge i_clk) begin
        if (launch) begin
            r_oa <= n_a; r_ox <= n_x; r_oy <= n_y; r_op <= n_p; r_opc <= n_pc;
            r_obusy <= (n_cyc != 3'd0);
            r_oexe <= r_exe && (r_cmd == CMD_TICK);
            r_ounk <= r_unk && r_exe && (r_cmd == CMD_TICK);
        end
    end

    assign o_res.valid          = r_ov;
    assign o_res.acc_value      = r_oa;
    assign o_res.index_x_value  = r_ox;
    assign o_res.index_y_value  = r_oy;
    assign o_res.stack_value    = r_sp;
    assign o_res.status_value   = r_op;
    assign o_res.counter_value  = r_opc;
    assign o_res.read_data      = r_o_rd;
    assign o_res.busy_res       = r_obusy;
    assign o_res.executed       = r_oexe;
    assign o_res.unknown_opcode = r_ounk;

    `CSC_ASSERT_IMPL(a_ready_idle, i_clk, i_rst_n, i_cmd.ready, r_state == S_IDLE, "ready outside idle")
    `CSC_ASSERT_NEXT(a_launch_valid, i_clk, i_rst_n, launch, o_res.valid, "launched result not shown")
    `CSC_ASSERT_IMPL(a_unk_exe, i_clk, i_rst_n, o_res.valid && o_res.unknown_opcode, o_res.executed, "unknown without execute")
    `CSC_ASSERT_IMPL(a_store_tick, i_clk, i_rst_n, mem_we && r_state != S_IDLE, r_dec.kind == K_STA, "store outside STA")
endmodule
`default_nettype wire

// ===== design/csc_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module csc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire
